### hw/rtl/sbb_pkg.sv
// Shared types, constants and the divide-by-five helper of the separable box blur.
`timescale 1ns / 1ps

package sbb_pkg;

    // Line store geometry and field widths.
    localparam int MAX_WIDTH   = 1024;
    localparam int STORED_ROWS = 4;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int LANE_W      = $clog2(STORED_ROWS);
    localparam int SUM_W       = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    // Frame size limits, stored as last column and last row and as plain sizes.
    localparam logic [COL_W-1:0] WIDTH_LAST_RESET  = COL_W'(639);
    localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = ROW_W'(479);
    localparam logic [COL_W-1:0] WIDTH_LAST_MIN    = COL_W'(4);
    localparam logic [COL_W-1:0] WIDTH_LAST_MAX    = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] HEIGHT_LAST_MIN   = ROW_W'(4);
    localparam logic [ROW_W-1:0] HEIGHT_LAST_MAX   = ROW_W'(4095);
    localparam logic [10:0]      WIDTH_MIN         = 11'd5;
    localparam logic [10:0]      WIDTH_MAX         = 11'(MAX_WIDTH);
    localparam logic [12:0]      HEIGHT_MIN        = 13'd5;
    localparam logic [12:0]      HEIGHT_MAX        = 13'd4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Reciprocal of five: floor(s * 1639 / 8192) equals floor(s / 5) for s below 1280.
    localparam int DIV5_MUL   = 1639;
    localparam int DIV5_SHIFT = 13;
    localparam int PROD_W     = SUM_W + 11;

    // How a result value is formed from the line store word.
    typedef enum logic [1:0] {
        K_VBLUR,
        K_STORE,
        K_PASS
    } t_kind;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One word of the line store: the same column of all stored rows.
    typedef t_rgb [STORED_ROWS-1:0] t_word;

    // One request to the line store stage: a column, an output row and its handling.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        t_rgb              hval;
        t_kind             kind;
        logic [LANE_W-1:0] lane_wr;
        logic              write;
        logic              emit;
        logic              last;
    } t_req;

    function automatic logic [7:0] div5(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(DIV5_MUL);
        return prod[DIV5_SHIFT+7:DIV5_SHIFT];
    endfunction

endpackage

### hw/rtl/sbb_in_if.sv
// Pixel input channel: one RGB pixel per beat.
`timescale 1ns / 1ps

interface sbb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

### hw/rtl/sbb_out_if.sv
// Result output channel: one blurred pixel with its coordinates per beat.
`timescale 1ns / 1ps

interface sbb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        run_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_column, output out_row, output run_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_column, input out_row, input run_last, output ready);
endinterface

### hw/rtl/sbb_front.sv
// Front end: pixel window, raster counters, horizontal sums and the request sequencer.
`timescale 1ns / 1ps

module sbb_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sbb_in_if.sink                             i_pix,
    input  logic                               i_cfg_we,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sbb_pkg::t_req                      o_req,
    output logic                               o_req_valid,
    input  logic                               i_req_ready
);
    import sbb_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

    // Frame geometry and raster position.
    logic [COL_W-1:0] r_w_last, n_w_last;
    logic [ROW_W-1:0] r_h_last, n_h_last;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_rgb             r_win [4];

    // Pixel group: the columns and rows that one accepted pixel makes known.
    logic              r_g_valid;
    logic [COL_W-1:0]  r_g_x0;
    logic              r_g_three;
    logic [ROW_W-1:0]  r_g_y0;
    logic [1:0]        r_g_nrow;
    t_kind             r_g_kind0;
    logic [LANE_W-1:0] r_g_lane;
    logic              r_g_pass0;
    t_sum              r_g_s0;
    t_rgb              r_g_h1;
    t_rgb              r_g_h2;
    logic [1:0]        r_g_j;
    logic [1:0]        r_g_k;

    t_rgb       cur;
    t_sum       sum;
    logic       pix_fire;
    logic       g_fire;
    logic       g_done;
    logic [1:0] klast;
    logic [1:0] jlast;
    logic       makes_cols;
    logic [1:0] nrow;
    logic       pass0;
    t_rgb       hval0;

    assign cur = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};

    // Five-tap sums of the current row, oldest window entry first.
    assign sum.red   = SUM_W'(r_win[0].red) + SUM_W'(r_win[1].red) + SUM_W'(r_win[2].red)
                     + SUM_W'(r_win[3].red) + SUM_W'(cur.red);
    assign sum.green = SUM_W'(r_win[0].green) + SUM_W'(r_win[1].green)
                     + SUM_W'(r_win[2].green) + SUM_W'(r_win[3].green) + SUM_W'(cur.green);
    assign sum.blue  = SUM_W'(r_win[0].blue) + SUM_W'(r_win[1].blue) + SUM_W'(r_win[2].blue)
                     + SUM_W'(r_win[3].blue) + SUM_W'(cur.blue);

    // Group sequencing: columns inner, rows outer.
    assign klast  = r_g_three ? 2'd2 : 2'd0;
    assign jlast  = (r_g_nrow == 2'd0) ? 2'd0 : r_g_nrow - 2'd1;
    assign g_done = (r_g_k == klast) && (r_g_j == jlast);
    assign g_fire = r_g_valid && i_req_ready;

    // A new pixel is taken while the group register is free or on its final beat.
    assign i_pix.ready = !r_g_valid || (g_fire && g_done);
    assign pix_fire    = i_pix.valid && i_pix.ready;

    // What the pixel at the current position makes known.
    assign makes_cols = (r_col >= COL_W'(2));
    assign pass0      = (r_col < COL_W'(4));
    always_comb begin
        if (r_row < ROW_W'(2)) begin
            nrow = 2'd0;
        end else if (r_row == r_h_last) begin
            nrow = 2'd3;
        end else begin
            nrow = 2'd1;
        end
    end

    // Clamp configuration values into last column and last row.
    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        if (i_cfg_we && i_cfg_index == CFG_FRAME_WIDTH) begin
            if (i_cfg_data[10:0] < WIDTH_MIN) begin
                n_w_last = WIDTH_LAST_MIN;
            end else if (i_cfg_data[10:0] > WIDTH_MAX) begin
                n_w_last = WIDTH_LAST_MAX;
            end else begin
                n_w_last = COL_W'(i_cfg_data[10:0] - 11'd1);
            end
        end
        if (i_cfg_we && i_cfg_index == CFG_FRAME_HEIGHT) begin
            if (i_cfg_data < HEIGHT_MIN) begin
                n_h_last = HEIGHT_LAST_MIN;
            end else if (i_cfg_data > HEIGHT_MAX) begin
                n_h_last = HEIGHT_LAST_MAX;
            end else begin
                n_h_last = ROW_W'(i_cfg_data - 13'd1);
            end
        end
    end

    // Geometry and raster counters; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= WIDTH_LAST_RESET;
            r_h_last <= HEIGHT_LAST_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            r_w_last <= n_w_last;
            r_h_last <= n_h_last;
            r_col    <= '0;
            r_row    <= '0;
        end else if (pix_fire) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Window of the four previous pixels of the row.
    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= cur;
        end
    end

    // Group control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_g_j     <= '0;
            r_g_k     <= '0;
        end else if (pix_fire && makes_cols) begin
            r_g_valid <= 1'b1;
            r_g_j     <= '0;
            r_g_k     <= '0;
        end else if (g_fire) begin
            if (g_done) begin
                r_g_valid <= 1'b0;
            end else if (r_g_k == klast) begin
                r_g_k <= '0;
                r_g_j <= r_g_j + 2'd1;
            end else begin
                r_g_k <= r_g_k + 2'd1;
            end
        end
    end

    // Group payload captured with the pixel.
    always_ff @(posedge i_clk) begin
        if (pix_fire && makes_cols) begin
            r_g_x0    <= r_col - COL_W'(2);
            r_g_three <= (r_col == r_w_last);
            r_g_y0    <= r_row - ROW_W'(2);
            r_g_nrow  <= nrow;
            r_g_kind0 <= (r_row < ROW_W'(4)) ? K_STORE : K_VBLUR;
            r_g_lane  <= r_row[LANE_W-1:0];
            r_g_pass0 <= pass0;
            r_g_s0    <= pass0 ? t_sum'{red:   SUM_W'(r_win[2].red),
                                        green: SUM_W'(r_win[2].green),
                                        blue:  SUM_W'(r_win[2].blue)} : sum;
            r_g_h1    <= r_win[3];
            r_g_h2    <= cur;
        end
    end

    // Horizontal result of the first column of the group.
    always_comb begin
        if (r_g_pass0) begin
            hval0 = '{red: r_g_s0.red[7:0], green: r_g_s0.green[7:0],
                      blue: r_g_s0.blue[7:0]};
        end else begin
            hval0 = '{red: div5(r_g_s0.red), green: div5(r_g_s0.green),
                      blue: div5(r_g_s0.blue)};
        end
    end

    // Request for the current column and row of the group.
    always_comb begin
        o_req.col     = r_g_x0 + COL_W'(r_g_k);
        o_req.row     = r_g_y0 + ROW_W'(r_g_j);
        o_req.lane_wr = r_g_lane;
        o_req.write   = (r_g_j == 2'd0);
        o_req.emit    = (r_g_nrow != 2'd0);
        o_req.last    = (r_g_nrow != 2'd0) && g_done;
        case (r_g_k)
            2'd0:    o_req.hval = hval0;
            2'd1:    o_req.hval = r_g_h1;
            default: o_req.hval = r_g_h2;
        endcase
        unique case (r_g_j)
            2'd0:    o_req.kind = r_g_kind0;
            2'd1:    o_req.kind = K_STORE;
            default: o_req.kind = K_PASS;
        endcase
    end

    assign o_req_valid = r_g_valid;

    // The raster position never passes the frame edge.
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_last)
        else $error("column counter beyond last column");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_h_last)
        else $error("row counter beyond last row");

    // A pixel never overwrites a group that still has beats to send.
    a_group_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_fire && makes_cols |-> !r_g_valid || (g_fire && g_done))
        else $error("pixel group overwritten");

endmodule

### hw/rtl/separable_box_blur_5x5_rgb.sv
// Top level: line store read-modify-write, vertical mean and output register.
`timescale 1ns / 1ps

// Channel    Dir  Beat contents
// i_pix      in   in_red, in_green, in_blue: next pixel in raster order
// o_res      out  out_red/green/blue, out_column, out_row, run_last
// i_cfg_*    in   register index and write data (frame_width, frame_height)
//
// One pixel per cycle in steady state while the output is not stalled; each pixel
// makes one request per result, or one per column when its row yields none. A row end
// makes three requests and the last pixel of a frame nine, all through the single read
// port of the line store. A result passes the group, store read and output registers.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
// A stalled output holds the store stage and the sequencer; a pixel is still taken
// while the sequencer is free.

module separable_box_blur_5x5_rgb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbb_in_if.sink                         i_pix,
    sbb_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbb_pkg::*;

    t_req  req;
    logic  req_valid;
    logic  req_ready;
    logic  rd_en;

    // Store stage: request plus the store word read for it.
    logic  r_a_valid;
    t_req  r_a;
    t_word r_rd_word;
    t_word r_mem [MAX_WIDTH];
    t_word n_wr_word;
    logic  a_fire;
    logic  mem_we;

    // Output register.
    logic             r_o_valid;
    t_rgb             r_o_pix;
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;
    logic             r_o_last;
    logic             o_free;
    t_rgb             n_o_pix;

    logic [SUM_W-1:0] vsum_r;
    logic [SUM_W-1:0] vsum_g;
    logic [SUM_W-1:0] vsum_b;

    sbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready)
    );

    // Handshake between the stages.
    assign o_free    = !r_o_valid || o_res.ready;
    assign a_fire    = r_a_valid && (!r_a.emit || o_free);
    assign req_ready = !r_a_valid || a_fire;
    assign rd_en     = req_valid && req_ready;
    assign mem_we    = a_fire && r_a.write;

    // Write back the word with this row's lane replaced by the horizontal result.
    always_comb begin
        n_wr_word             = r_rd_word;
        n_wr_word[r_a.lane_wr] = r_a.hval;
    end

    // Line store: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_word <= r_mem[req.col[ADDR_W-1:0]];
        end
        if (mem_we) begin
            r_mem[r_a.col[ADDR_W-1:0]] <= n_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (req_ready) begin
            r_a_valid <= req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a <= req;
        end
    end

    // Vertical sums: the four stored rows plus the current horizontal result.
    assign vsum_r = SUM_W'(r_a.hval.red) + SUM_W'(r_rd_word[0].red)
                  + SUM_W'(r_rd_word[1].red) + SUM_W'(r_rd_word[2].red)
                  + SUM_W'(r_rd_word[3].red);
    assign vsum_g = SUM_W'(r_a.hval.green) + SUM_W'(r_rd_word[0].green)
                  + SUM_W'(r_rd_word[1].green) + SUM_W'(r_rd_word[2].green)
                  + SUM_W'(r_rd_word[3].green);
    assign vsum_b = SUM_W'(r_a.hval.blue) + SUM_W'(r_rd_word[0].blue)
                  + SUM_W'(r_rd_word[1].blue) + SUM_W'(r_rd_word[2].blue)
                  + SUM_W'(r_rd_word[3].blue);

    // Result value by kind: vertical mean, stored edge row, or the current row.
    always_comb begin
        unique case (r_a.kind)
            K_VBLUR: n_o_pix = '{red: div5(vsum_r), green: div5(vsum_g),
                                 blue: div5(vsum_b)};
            K_STORE: n_o_pix = r_rd_word[r_a.row[LANE_W-1:0]];
            default: n_o_pix = r_a.hval;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_fire && r_a.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && r_a.emit) begin
            r_o_pix  <= n_o_pix;
            r_o_col  <= r_a.col;
            r_o_row  <= r_a.row;
            r_o_last <= r_a.last;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.out_red    = r_o_pix.red;
    assign o_res.out_green  = r_o_pix.green;
    assign o_res.out_blue   = r_o_pix.blue;
    assign o_res.out_column = r_o_col;
    assign o_res.out_row    = r_o_row;
    assign o_res.run_last   = r_o_last;

    // A read that meets a write to the same column must not need the lane being written.
    a_no_raw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && mem_we && req.col == r_a.col |->
            req.kind == K_PASS || (req.kind == K_STORE && req.row[LANE_W-1:0] != r_a.lane_wr))
        else $error("store read overlaps a write it depends on");

    // Vertical means only come from the first row of a group, which writes the store.
    a_vblur_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a.kind == K_VBLUR |-> r_a.write)
        else $error("vertical mean request without store write");

    // Beats that produce no result exist only to write the store.
    a_silent_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !r_a.emit |-> r_a.write && !r_a.last)
        else $error("silent request that does not write the store");

endmodule

### tb/blur_checker.sv
// Checker for the separable box blur: watches both channels, predicts each beat and compares.
`timescale 1ns / 1ps

module blur_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbb_in_if                              i_pix,
    sbb_out_if                             i_res,
    input  logic                           i_cfg_we,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_failures,
    output int                             o_pending,
    output int                             o_results
);
    import sbb_pkg::*;

    localparam int TAPS          = 5;
    localparam int RADIUS        = 2;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int HEIGHT_LIMIT  = 4096;

    // One blurred pixel as it should leave the block.
    typedef struct {
        t_rgb        rgb;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } t_blurred;

    t_blurred    blurred_expected [$];
    logic [10:0] frame_width;
    logic [12:0] frame_height;
    int          col_pos;
    int          row_pos;
    t_rgb        row_window [4];
    t_rgb        line_store [STORED_ROWS][MAX_WIDTH];
    int          failures = 0;
    int          results = 0;
    int          pending = 0;

    assign o_failures = failures;
    assign o_pending  = pending;
    assign o_results  = results;

    // Truncated mean of five pixels, channel by channel.
    function automatic t_rgb mean5(input t_rgb p0, input t_rgb p1, input t_rgb p2,
                                   input t_rgb p3, input t_rgb p4);
        t_rgb m;
        m.red   = 8'((32'(p0.red) + p1.red + p2.red + p3.red + p4.red) / TAPS);
        m.green = 8'((32'(p0.green) + p1.green + p2.green + p3.green + p4.green) / TAPS);
        m.blue  = 8'((32'(p0.blue) + p1.blue + p2.blue + p3.blue + p4.blue) / TAPS);
        return m;
    endfunction

    // Work out every blurred pixel that one input pixel completes, then advance.
    task automatic predict_blur(input t_rgb px);
        int       w;
        int       h;
        int       c;
        int       r;
        int       x;
        int       y;
        int       ncol;
        int       nrow;
        int       cols [3];
        int       rows [3];
        t_rgb     hv [3];
        t_blurred b;
        w = int'(frame_width);
        if (w < TAPS) w = TAPS;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(frame_height);
        if (h < TAPS) h = TAPS;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        c = col_pos;
        r = row_pos;
        ncol = 0;
        nrow = 0;

        // Horizontal results: edge columns pass through, inner ones are averaged.
        if (c >= RADIUS) begin
            x = c - RADIUS;
            if (x < RADIUS) begin
                hv[0] = row_window[2];
            end else begin
                hv[0] = mean5(row_window[0], row_window[1], row_window[2], row_window[3], px);
            end
            cols[0] = x;
            ncol = 1;
        end
        if (c == w - 1) begin
            hv[ncol]       = row_window[3];
            hv[ncol + 1]   = px;
            cols[ncol]     = w - 2;
            cols[ncol + 1] = w - 1;
            ncol = ncol + 2;
        end

        // Rows that this pixel lets out; the last row of a frame flushes two more.
        if (r >= RADIUS) begin
            rows[nrow] = r - RADIUS;
            nrow = nrow + 1;
        end
        if (r == h - 1) begin
            rows[nrow]     = h - 2;
            rows[nrow + 1] = h - 1;
            nrow = nrow + 2;
        end

        // Vertical pass over stored horizontal results, row by row.
        for (int j = 0; j < nrow; j++) begin
            y = rows[j];
            for (int k = 0; k < ncol; k++) begin
                x = cols[k];
                if (y == r) begin
                    b.rgb = hv[k];
                end else if (y < RADIUS || y > h - 3) begin
                    b.rgb = line_store[y % STORED_ROWS][x];
                end else begin
                    b.rgb = mean5(hv[k], line_store[(r - 1) % STORED_ROWS][x],
                                  line_store[(r - 2) % STORED_ROWS][x],
                                  line_store[(r - 3) % STORED_ROWS][x],
                                  line_store[(r - 4) % STORED_ROWS][x]);
                end
                b.col  = 10'(x);
                b.row  = 12'(y);
                b.last = (j == nrow - 1) && (k == ncol - 1);
                blurred_expected.insert(blurred_expected.size(), b);
            end
        end

        // Keep this row's horizontal results and slide the pixel window.
        for (int k = 0; k < ncol; k++) begin
            line_store[r % STORED_ROWS][cols[k]] = hv[k];
        end
        row_window[0] = row_window[1];
        row_window[1] = row_window[2];
        row_window[2] = row_window[3];
        row_window[3] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            failures++;
        end
    endtask

    // Model update and comparison, both on the rising edge.
    always @(posedge i_clk) begin
        t_blurred b;
        if (!i_rst_n) begin
            frame_width  = 11'(RESET_WIDTH);
            frame_height = 13'(RESET_HEIGHT);
            col_pos = 0;
            row_pos = 0;
            for (int i = 0; i < 4; i++) row_window[i] = '0;
            blurred_expected.delete();
        end else begin
            // A register write also restarts the frame.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    frame_width = i_cfg_data[10:0];
                end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    frame_height = i_cfg_data[12:0];
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (i_pix.valid && i_pix.ready) begin
                predict_blur(t_rgb'({i_pix.in_red, i_pix.in_green, i_pix.in_blue}));
            end
            if (i_res.valid && i_res.ready) begin
                results++;
                if (blurred_expected.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual row %0d column %0d",
                             $time, i_res.out_row, i_res.out_column);
                    failures++;
                end else begin
                    b = blurred_expected.pop_front();
                    check_field("out_red", b.rgb.red, i_res.out_red);
                    check_field("out_green", b.rgb.green, i_res.out_green);
                    check_field("out_blue", b.rgb.blue, i_res.out_blue);
                    check_field("out_column", b.col, i_res.out_column);
                    check_field("out_row", b.row, i_res.out_row);
                    check_field("run_last", b.last, i_res.run_last);
                end
            end
        end
        pending = blurred_expected.size();
    end

endmodule

### tb/testbench.sv
// Top of the box blur testbench: clock, reset, pixel stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import sbb_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 25;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HEAD_PIXELS    = 8;
    localparam int RANDOM_PIXELS  = 44;
    localparam int RESET_WIDTH    = 640;
    localparam int MIN_SIZE       = 5;

    // Pixel patterns for the frames.
    localparam int STYLE_RANDOM   = 0;
    localparam int STYLE_PLANES   = 1;
    localparam int STYLE_INVERTED = 2;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  calm;
    int                    mismatch_count;
    int                    expected_left;
    int                    results_seen;
    int                    pixels_sent;
    int                    settings_count;
    int                    stall_cycles = 0;

    sbb_in_if  pix ();
    sbb_out_if res ();

    separable_box_blur_5x5_rgb u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blur_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix),
        .i_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (mismatch_count),
        .o_pending   (expected_left),
        .o_results   (results_seen)
    );

    always #HALF_PERIOD clk = ~clk;

    // Output side stalls at random except during calm stretches.
    always @(negedge clk) begin
        res.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog: too many cycles without any beat or register write ends the run.
    always @(posedge clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     expected_left);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one pixel, possibly after some idle cycles, and hold it until taken.
    task automatic send_pixel(input t_rgb px);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid    <= 1'b1;
        pix.in_red   <= px.red;
        pix.in_green <= px.green;
        pix.in_blue  <= px.blue;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        @(negedge clk);
        pixels_sent++;
    endtask

    // Stop sending and wait until every predicted result has left the block.
    task automatic wait_drained(input int extra);
        pix.valid <= 1'b0;
        do @(negedge clk); while (expected_left != 0);
        repeat (extra) @(negedge clk);
    endtask

    // Write both frame registers; only called while the block is idle.
    task automatic configure(input int width, input int height);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(height);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Random pixel, with a bias toward the channel extremes.
    function automatic t_rgb random_pixel();
        t_rgb px;
        px.red   = ($urandom_range(9) == 0) ? {8{1'($urandom)}} : 8'($urandom_range(255));
        px.green = ($urandom_range(9) == 0) ? {8{1'($urandom)}} : 8'($urandom_range(255));
        px.blue  = ($urandom_range(9) == 0) ? {8{1'($urandom)}} : 8'($urandom_range(255));
        return px;
    endfunction

    // Stream a run of pixels in raster order; optionally pause once for all results.
    task automatic send_frame(input int width, input int count, input int style,
                              input int pause_at);
        t_rgb px;
        logic odd;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_drained(0);
            odd = 1'((i / width + i % width) & 1);
            if (style == STYLE_PLANES) begin
                px = {8'hFF, 8'h00, {8{odd}}};
            end else if (style == STYLE_INVERTED) begin
                px = {8'h00, 8'hFF, {8{~odd}}};
            end else begin
                px = random_pixel();
            end
            send_pixel(px);
        end
    endtask

    initial begin
        int reg_w;
        int reg_h;
        int eff_w;
        int eff_h;
        int count;
        int pick;
        int pause_at;
        int random_sent;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FRAME_WIDTH;
        cfg_data       = '0;
        calm           = 1'b0;
        pix.valid      = 1'b0;
        pix.in_red     = '0;
        pix.in_green   = '0;
        pix.in_blue    = '0;
        pixels_sent    = 0;
        settings_count = 0;
        random_sent    = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset frame size: a few pixels of the first row, which only fill the line store.
        send_frame(RESET_WIDTH, HEAD_PIXELS, STYLE_RANDOM, -1);

        // Smallest frame with saturated and alternating channels, no idling on either side.
        wait_drained(SETTLE_CYCLES);
        configure(MIN_SIZE, MIN_SIZE);
        calm = 1'b1;
        send_frame(MIN_SIZE, MIN_SIZE * MIN_SIZE, STYLE_PLANES, -1);

        // Sizes below the minimum clamp up to it.
        wait_drained(SETTLE_CYCLES);
        configure(0, 2);
        send_frame(MIN_SIZE, MIN_SIZE * MIN_SIZE, STYLE_INVERTED, -1);
        calm = 1'b0;

        // All-ones registers clamp to the largest frame; the start of its first row.
        wait_drained(SETTLE_CYCLES);
        configure(2047, 8191);
        send_frame(MAX_WIDTH, HEAD_PIXELS, STYLE_RANDOM, -1);

        // Random small frames, whole, cut short or running on, with one forced pause.
        while (random_sent < RANDOM_PIXELS) begin
            reg_w = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(9, 5);
            reg_h = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(8, 5);
            eff_w = (reg_w < MIN_SIZE) ? MIN_SIZE : reg_w;
            eff_h = (reg_h < MIN_SIZE) ? MIN_SIZE : reg_h;
            count = eff_w * eff_h;
            if (random_sent == 0) begin
                pause_at = 2 * eff_w + 3;
            end else begin
                pick = $urandom_range(2);
                if (pick == 0) begin
                    count = $urandom_range(count - 1, 1);
                end else if (pick == 1) begin
                    count += $urandom_range(2 * eff_w, 1);
                end
                pause_at = ($urandom_range(3) == 0) ? $urandom_range(count - 1) : -1;
            end
            if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
            wait_drained(SETTLE_CYCLES);
            configure(reg_w, reg_h);
            send_frame(eff_w, count, STYLE_RANDOM, pause_at);
            random_sent += count;
        end

        wait_drained(SETTLE_CYCLES);
        $display("Covered %0d pixels and %0d blurred results over %0d frame settings,",
                 pixels_sent, results_seen, settings_count);
        $display("including clamped sizes, partial frames, frame ends and restarts.");
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_in_if.sv
hw/rtl/sbb_out_if.sv
hw/rtl/sbb_front.sv
hw/rtl/separable_box_blur_5x5_rgb.sv
tb/blur_checker.sv
tb/testbench.sv
